@@ sv/svdm_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo duty motion profiler package
// Operation codes, register indexes, reset values and the command and
// status bundles exchanged between the controller and the datapath.
// ---------------------------------------------------------------------------
package svdm_pkg;

  localparam int OP_W      = 3;
  localparam int LVL_W     = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [OP_W-1:0] OP_TICK      = 3'd0;
  localparam logic [OP_W-1:0] OP_SET_LEVEL = 3'd1;
  localparam logic [OP_W-1:0] OP_SET_DUTY  = 3'd2;
  localparam logic [OP_W-1:0] OP_ENABLE    = 3'd3;
  localparam logic [OP_W-1:0] OP_DISABLE   = 3'd4;

  localparam logic [CFG_IDX_W-1:0] REG_MAX_ACCEL       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MAX_VELOCITY    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_FLOOR      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_CEILING    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_CURRENT_LIMIT   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT     = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_ZERO_DUTY = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_LEVEL_STEP_DUTY = 3'd7;

  localparam int RST_MAX_ACCEL       = 65;
  localparam int RST_MAX_VELOCITY    = 655;
  localparam int RST_DUTY_FLOOR      = 1638;
  localparam int RST_DUTY_CEILING    = 8192;
  localparam int RST_CURRENT_LIMIT   = 4095;
  localparam int RST_LEVEL_COUNT     = 10;
  localparam int RST_LEVEL_ZERO_DUTY = 1638;
  localparam int RST_LEVEL_STEP_DUTY = 346;

  typedef struct packed {
    logic idle;
    logic exec;
    logic mag;
    logic mul;
    logic root_go;
    logic ideal;
    logic accel;
    logic move;
    logic reach;
    logic push;
  } cmd_t;

  typedef struct packed {
    logic ramp;
    logic root_done;
    logic out_free;
  } stat_t;

endpackage

@@ sv/svdm_ifs.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo duty motion profiler channels
// Valid/ready channels for commands, results and register writes.
// ---------------------------------------------------------------------------
interface svdm_in_if #(
  parameter int ADC_W  = 12,
  parameter int DUTY_W = 17
);
  logic                          valid;
  logic                          ready;
  logic [svdm_pkg::OP_W-1:0]     operation;
  logic [svdm_pkg::LVL_W-1:0]    level;
  logic [DUTY_W-1:0]             duty_request;
  logic [ADC_W-1:0]              adc_sample;
  logic                          comparator_ok;

  modport source (output valid, operation, level, duty_request, adc_sample,
                  comparator_ok, input ready);
  modport sink (input valid, operation, level, duty_request, adc_sample,
                comparator_ok, output ready);
endinterface

interface svdm_out_if #(
  parameter int DUTY_W = 17
);
  logic              valid;
  logic              ready;
  logic              accepted;
  logic [DUTY_W-1:0] duty_out;
  logic              at_target;
  logic              is_enabled;
  logic              current_fault;

  modport source (output valid, accepted, duty_out, at_target, is_enabled,
                  current_fault, input ready);
  modport sink (input valid, accepted, duty_out, at_target, is_enabled,
                current_fault, output ready);
endinterface

interface svdm_cfg_if #(
  parameter int DATA_W = 17
);
  logic                             valid;
  logic                             ready;
  logic [svdm_pkg::CFG_IDX_W-1:0]   index;
  logic [DATA_W-1:0]                data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

@@ sv/svdm_ctrl.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo duty motion profiler controller
// Sequences one item at a time through decode, the ramp steps and delivery.
// ---------------------------------------------------------------------------
module svdm_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  input  svdm_pkg::stat_t st,
  output svdm_pkg::cmd_t  cmd
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_MUL,
    S_ROOT_GO,
    S_ROOT,
    S_IDEAL,
    S_ACCEL,
    S_MOVE,
    S_REACH,
    S_PUSH
  } state_t;

  state_t state_r;
  state_t state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        cmd.idle = 1'b1;
        if (in_valid) begin
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        if (st.ramp) begin
          cmd.mag   = 1'b1;
          state_nxt = S_MUL;
        end else begin
          cmd.exec  = 1'b1;
          state_nxt = S_PUSH;
        end
      end
      S_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_ROOT_GO;
      end
      S_ROOT_GO: begin
        cmd.root_go = 1'b1;
        state_nxt   = S_ROOT;
      end
      S_ROOT: begin
        if (st.root_done) begin
          state_nxt = S_IDEAL;
        end
      end
      S_IDEAL: begin
        cmd.ideal = 1'b1;
        state_nxt = S_ACCEL;
      end
      S_ACCEL: begin
        cmd.accel = 1'b1;
        state_nxt = S_MOVE;
      end
      S_MOVE: begin
        cmd.move  = 1'b1;
        state_nxt = S_REACH;
      end
      S_REACH: begin
        cmd.reach = 1'b1;
        state_nxt = S_PUSH;
      end
      S_PUSH: begin
        if (st.out_free) begin
          cmd.push  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

@@ sv/svdm_sqrt.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo duty motion profiler square root
// Bit-serial integer square root, rounded down, one root bit per cycle.
// ---------------------------------------------------------------------------
module svdm_sqrt #(
  parameter int QW = 17
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [2*QW-1:0] radicand,
  output logic            done,
  output logic [QW-1:0]   root
);

  localparam int CW = $clog2(QW + 1);
  localparam int TW = QW + 3;

  logic            busy_r;
  logic [CW-1:0]   cnt_r;
  logic [2*QW-1:0] rad_r;
  logic [QW:0]     rem_r;
  logic [QW-1:0]   root_r;

  logic [TW-1:0]   trial;
  logic [TW-1:0]   cand;
  logic [TW-1:0]   diff;
  logic [QW:0]     rem_nxt;
  logic [QW-1:0]   root_nxt;

  assign trial = {rem_r, rad_r[2*QW-1 -: 2]};
  assign cand  = {1'b0, root_r, 2'b01};
  assign diff  = trial - cand;

  always_comb begin
    if (trial >= cand) begin
      rem_nxt  = diff[QW:0];
      root_nxt = {root_r[QW-2:0], 1'b1};
    end else begin
      rem_nxt  = trial[QW:0];
      root_nxt = {root_r[QW-2:0], 1'b0};
    end
  end

  assign done = busy_r && (cnt_r == '0);
  assign root = root_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= CW'(QW);
    end else if (busy_r) begin
      if (cnt_r == '0) begin
        busy_r <= 1'b0;
      end else begin
        cnt_r <= cnt_r - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rad_r  <= radicand;
      rem_r  <= '0;
      root_r <= '0;
    end else if (busy_r && (cnt_r != '0)) begin
      rad_r  <= {rad_r[2*QW-3:0], 2'b00};
      rem_r  <= rem_nxt;
      root_r <= root_nxt;
    end
  end

endmodule

@@ sv/svdm_dp.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo duty motion profiler datapath
// Registers, item latch, ramp arithmetic, square root and result register.
// ---------------------------------------------------------------------------
module svdm_dp #(
  parameter int ADC_W = 12,
  parameter int F     = 16,
  parameter int CFG_W = 17
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  svdm_pkg::cmd_t                 cmd,
  output svdm_pkg::stat_t                st,
  input  logic                           in_valid,
  input  logic [svdm_pkg::OP_W-1:0]      in_operation,
  input  logic [svdm_pkg::LVL_W-1:0]     in_level,
  input  logic [F:0]                     in_duty_request,
  input  logic [ADC_W-1:0]               in_adc_sample,
  input  logic                           in_comparator_ok,
  input  logic                           cfg_valid,
  input  logic [svdm_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]               cfg_data,
  input  logic                           out_ready,
  output logic                           out_valid,
  output logic                           out_accepted,
  output logic [F:0]                     out_duty_out,
  output logic                           out_at_target,
  output logic                           out_is_enabled,
  output logic                           out_current_fault
);

  localparam int DW  = F + 1;
  localparam int AW  = F;
  localparam int VW  = F + 2;
  localparam int SW  = F + 4;
  localparam int RW  = 2 * DW;
  localparam int PRW = AW + DW;
  localparam int GLW = DW + svdm_pkg::LVL_W + 1;
  localparam logic [DW-1:0]  ONE_D  = DW'(1) << F;
  localparam logic [GLW-1:0] ONE_GL = GLW'(1) << F;

  logic [AW-1:0]                   accel_r;
  logic [DW-1:0]                   vmax_r;
  logic [DW-1:0]                   floor_r;
  logic [DW-1:0]                   ceil_r;
  logic [ADC_W-1:0]                limit_r;
  logic [svdm_pkg::LVL_W-1:0]      lvlcnt_r;
  logic [DW-1:0]                   lvl0_r;
  logic [DW-1:0]                   lvlstep_r;

  logic [svdm_pkg::OP_W-1:0]       op_r;
  logic [svdm_pkg::LVL_W-1:0]      level_r;
  logic [DW-1:0]                   req_r;
  logic [ADC_W-1:0]                adc_r;
  logic                            cmp_r;

  logic                            en_r, en_nxt;
  logic                            reached_r, reached_nxt;
  logic [DW-1:0]                   duty_r, duty_nxt;
  logic [DW-1:0]                   goal_r, goal_nxt;
  logic signed [VW-1:0]            vel_r, vel_nxt;
  logic                            ok_r, ok_nxt;
  logic                            fault_r, fault_nxt;
  logic                            neg_r, neg_nxt;
  logic [DW-1:0]                   mag_r, mag_nxt;
  logic [RW-1:0]                   prod_r, prod_nxt;
  logic signed [SW-1:0]            ideal_r, ideal_nxt;
  logic                            out_valid_r;
  logic                            res_ok_r;
  logic [DW-1:0]                   res_duty_r;
  logic                            res_tgt_r;
  logic                            res_en_r;
  logic                            res_flt_r;

  logic                            good;
  logic [GLW-1:0]                  level_goal;
  logic signed [SW-1:0]            dist_s;
  logic signed [SW-1:0]            gap_s;
  logic signed [SW-1:0]            vel_ext;
  logic signed [SW-1:0]            acc_s;
  logic signed [SW-1:0]            err_s;
  logic signed [SW-1:0]            pos_s;
  logic signed [SW-1:0]            pos_lo;
  logic signed [SW-1:0]            floor_s;
  logic signed [SW-1:0]            ceil_s;
  logic signed [SW-1:0]            vmax_s;
  logic [DW-1:0]                   root;
  logic [DW-1:0]                   root_cl;
  logic                            root_done;

  svdm_sqrt #(.QW(DW)) u_sqrt (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.root_go),
    .radicand (prod_r),
    .done     (root_done),
    .root     (root)
  );

  assign good       = cmp_r && (adc_r <= limit_r);
  assign level_goal = GLW'(lvl0_r) + GLW'(level_r) * GLW'(lvlstep_r);
  assign dist_s     = $signed(SW'(goal_r)) - $signed(SW'(duty_r));
  assign gap_s      = $signed(SW'(duty_r)) - $signed(SW'(goal_r));
  assign vel_ext    = SW'(vel_r);
  assign acc_s      = $signed(SW'(accel_r));
  assign err_s      = ideal_r - vel_ext;
  assign pos_s      = $signed(SW'(duty_r)) + vel_ext;
  assign floor_s    = $signed(SW'(floor_r));
  assign ceil_s     = $signed(SW'(ceil_r));
  assign vmax_s     = $signed(SW'(vmax_r));
  assign pos_lo     = (pos_s < floor_s) ? floor_s : pos_s;
  assign root_cl    = (root > vmax_r) ? vmax_r : root;

  assign st.ramp      = (op_r == svdm_pkg::OP_TICK) && en_r && good && !reached_r;
  assign st.root_done = root_done;
  assign st.out_free  = !out_valid_r || out_ready;

  always_comb begin
    en_nxt      = en_r;
    reached_nxt = reached_r;
    duty_nxt    = duty_r;
    goal_nxt    = goal_r;
    vel_nxt     = vel_r;
    ok_nxt      = ok_r;
    fault_nxt   = fault_r;
    neg_nxt     = neg_r;
    mag_nxt     = mag_r;
    prod_nxt    = prod_r;
    ideal_nxt   = ideal_r;

    if (cmd.exec) begin
      ok_nxt    = 1'b0;
      fault_nxt = 1'b0;
      case (op_r)
        svdm_pkg::OP_TICK: begin
          if (en_r) begin
            if (!good) begin
              en_nxt    = 1'b0;
              vel_nxt   = '0;
              fault_nxt = 1'b1;
            end else begin
              ok_nxt = 1'b1;
            end
          end
        end
        svdm_pkg::OP_SET_LEVEL: begin
          if (level_r < lvlcnt_r) begin
            reached_nxt = 1'b0;
            vel_nxt     = '0;
            if (level_goal <= ONE_GL) begin
              goal_nxt = DW'(level_goal);
              ok_nxt   = 1'b1;
            end
          end
        end
        svdm_pkg::OP_SET_DUTY: begin
          if (req_r <= ONE_D) begin
            goal_nxt    = req_r;
            reached_nxt = 1'b0;
            vel_nxt     = '0;
            ok_nxt      = 1'b1;
          end
        end
        svdm_pkg::OP_ENABLE: begin
          if (en_r) begin
            ok_nxt = 1'b1;
          end else if (!good) begin
            fault_nxt = 1'b1;
          end else begin
            en_nxt  = 1'b1;
            vel_nxt = '0;
            ok_nxt  = 1'b1;
          end
        end
        svdm_pkg::OP_DISABLE: begin
          if (en_r) begin
            en_nxt  = 1'b0;
            vel_nxt = '0;
          end
          ok_nxt = 1'b1;
        end
        default: begin
          ok_nxt = 1'b0;
        end
      endcase
    end

    if (cmd.mag) begin
      ok_nxt    = 1'b1;
      fault_nxt = 1'b0;
      neg_nxt   = dist_s < 0;
      mag_nxt   = (dist_s < 0) ? DW'(-dist_s) : DW'(dist_s);
    end

    if (cmd.mul) begin
      prod_nxt = {PRW'(accel_r) * PRW'(mag_r), 1'b0};
    end

    if (cmd.ideal) begin
      ideal_nxt = neg_r ? -$signed(SW'(root_cl)) : $signed(SW'(root_cl));
    end

    if (cmd.accel) begin
      if (err_s > acc_s) begin
        vel_nxt = VW'(vel_ext + acc_s);
      end else if (err_s < -acc_s) begin
        vel_nxt = VW'(vel_ext - acc_s);
      end else begin
        vel_nxt = VW'(ideal_r);
      end
    end

    if (cmd.move) begin
      duty_nxt = (pos_lo > ceil_s) ? DW'(ceil_s) : DW'(pos_lo);
    end

    if (cmd.reach) begin
      if (((gap_s < 0) ? -gap_s : gap_s) < vmax_s) begin
        reached_nxt = 1'b1;
        vel_nxt     = '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      accel_r     <= AW'(svdm_pkg::RST_MAX_ACCEL);
      vmax_r      <= DW'(svdm_pkg::RST_MAX_VELOCITY);
      floor_r     <= DW'(svdm_pkg::RST_DUTY_FLOOR);
      ceil_r      <= DW'(svdm_pkg::RST_DUTY_CEILING);
      limit_r     <= ADC_W'(svdm_pkg::RST_CURRENT_LIMIT);
      lvlcnt_r    <= svdm_pkg::LVL_W'(svdm_pkg::RST_LEVEL_COUNT);
      lvl0_r      <= DW'(svdm_pkg::RST_LEVEL_ZERO_DUTY);
      lvlstep_r   <= DW'(svdm_pkg::RST_LEVEL_STEP_DUTY);
      en_r        <= 1'b0;
      reached_r   <= 1'b0;
      duty_r      <= '0;
      goal_r      <= '0;
      vel_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_index)
          svdm_pkg::REG_MAX_ACCEL:       accel_r   <= cfg_data[AW-1:0];
          svdm_pkg::REG_MAX_VELOCITY:    vmax_r    <= cfg_data[DW-1:0];
          svdm_pkg::REG_DUTY_FLOOR:      floor_r   <= cfg_data[DW-1:0];
          svdm_pkg::REG_DUTY_CEILING:    ceil_r    <= cfg_data[DW-1:0];
          svdm_pkg::REG_CURRENT_LIMIT:   limit_r   <= cfg_data[ADC_W-1:0];
          svdm_pkg::REG_LEVEL_COUNT:     lvlcnt_r  <= cfg_data[svdm_pkg::LVL_W-1:0];
          svdm_pkg::REG_LEVEL_ZERO_DUTY: lvl0_r    <= cfg_data[DW-1:0];
          svdm_pkg::REG_LEVEL_STEP_DUTY: lvlstep_r <= cfg_data[DW-1:0];
          default: begin
            accel_r <= accel_r;
          end
        endcase
      end
      en_r      <= en_nxt;
      reached_r <= reached_nxt;
      duty_r    <= duty_nxt;
      goal_r    <= goal_nxt;
      vel_r     <= vel_nxt;
      if (cmd.push) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.idle && in_valid) begin
      op_r    <= in_operation;
      level_r <= in_level;
      req_r   <= in_duty_request;
      adc_r   <= in_adc_sample;
      cmp_r   <= in_comparator_ok;
    end
  end

  always_ff @(posedge clk) begin
    ok_r    <= ok_nxt;
    fault_r <= fault_nxt;
    neg_r   <= neg_nxt;
    mag_r   <= mag_nxt;
    prod_r  <= prod_nxt;
    ideal_r <= ideal_nxt;
    if (cmd.push) begin
      res_ok_r   <= ok_r;
      res_duty_r <= duty_r;
      res_tgt_r  <= reached_r;
      res_en_r   <= en_r;
      res_flt_r  <= fault_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_accepted      = res_ok_r;
  assign out_duty_out      = res_duty_r;
  assign out_at_target     = res_tgt_r;
  assign out_is_enabled    = res_en_r;
  assign out_current_fault = res_flt_r;

endmodule

@@ sv/servo_duty_motion_profiler.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo duty motion profiler
// Ramps a Q16 servo PWM duty toward a goal under velocity and acceleration
// limits, with current supervision, level and duty commands.
// ---------------------------------------------------------------------------
//  Channel  Direction  Beat contents
//  in_ch    sink       operation, level, duty_request, adc_sample, comparator_ok
//  out_ch   source     accepted, duty_out, at_target, is_enabled, current_fault
//  cfg_ch   sink       index, data (register write, always ready)
//
//  A ramping tick passes through decode, the acceleration-distance product and the
//  bit-serial square root that yields one root bit a cycle, then the ideal, accel,
//  move and reach steps; other items skip them. One item is worked on at a time.
//  The output register holds one finished result, so the next item is taken
//  while that result waits; an item completes only once the register is free.
//  Reset is synchronous and active low and restores the register defaults.
// ---------------------------------------------------------------------------
module servo_duty_motion_profiler #(
  parameter int ADC_BITS       = 12,
  parameter int DUTY_FRAC_BITS = 16
) (
  input logic       clk,
  input logic       rst_n,
  svdm_in_if.sink   in_ch,
  svdm_out_if.source out_ch,
  svdm_cfg_if.sink  cfg_ch
);

  localparam int CFG_W = (DUTY_FRAC_BITS + 1 > ADC_BITS) ? DUTY_FRAC_BITS + 1 : ADC_BITS;

  svdm_pkg::cmd_t  cmd;
  svdm_pkg::stat_t st;

  assign in_ch.ready  = cmd.idle;
  assign cfg_ch.ready = 1'b1;

  svdm_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .st       (st),
    .cmd      (cmd)
  );

  svdm_dp #(
    .ADC_W (ADC_BITS),
    .F     (DUTY_FRAC_BITS),
    .CFG_W (CFG_W)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .st                (st),
    .in_valid          (in_ch.valid),
    .in_operation      (in_ch.operation),
    .in_level          (in_ch.level),
    .in_duty_request   (in_ch.duty_request),
    .in_adc_sample     (in_ch.adc_sample),
    .in_comparator_ok  (in_ch.comparator_ok),
    .cfg_valid         (cfg_ch.valid),
    .cfg_index         (cfg_ch.index),
    .cfg_data          (cfg_ch.data),
    .out_ready         (out_ch.ready),
    .out_valid         (out_ch.valid),
    .out_accepted      (out_ch.accepted),
    .out_duty_out      (out_ch.duty_out),
    .out_at_target     (out_ch.at_target),
    .out_is_enabled    (out_ch.is_enabled),
    .out_current_fault (out_ch.current_fault)
  );

endmodule

@@ sv/svdm_checker.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Servo duty motion profiler checker
// Port-level properties of the profiler, bound to the top level.
// ---------------------------------------------------------------------------
module svdm_checker (
  input logic clk,
  input logic rst_n,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic out_accepted,
  input logic out_is_enabled,
  input logic out_current_fault
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("Result beat dropped before it was taken.");

  a_fault_not_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_current_fault |-> !out_accepted)
    else $error("A current fault was reported as a successful operation.");

  a_fault_disables: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_current_fault |-> !out_is_enabled)
    else $error("A current fault left the driver enabled.");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("A second item was taken before the first was processed.");

endmodule

bind servo_duty_motion_profiler svdm_checker u_svdm_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_accepted      (out_ch.accepted),
  .out_is_enabled    (out_ch.is_enabled),
  .out_current_fault (out_ch.current_fault)
);
